FILE: hw/rtl/text_to_int64_parser_macros.svh
// Assertion macros shared by the parser RTL.
`ifndef TEXT_TO_INT64_PARSER_MACROS_SVH
`define TEXT_TO_INT64_PARSER_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define T2I_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside of reset.
`define T2I_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/t2i_pkg.sv
package t2i_pkg;

  localparam int unsigned POS_W   = 12;
  localparam int unsigned BASE_W  = 6;
  localparam int unsigned DIG_W   = 6;
  localparam logic [POS_W-1:0] MAX_LEN = 12'd4095;

  localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_MAX = 64'h8000_0000_0000_0000;

  localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
  localparam logic [BASE_W-1:0] BASE_ONE  = 6'd1;
  localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;
  localparam logic [BASE_W-1:0] BASE_TOP  = 6'd36;

  localparam logic [DIG_W-1:0] DIG_NONE = 6'd63;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UPA   = 8'h41;
  localparam logic [7:0] CH_UPZ   = 8'h5A;
  localparam logic [7:0] CH_LOA   = 8'h61;
  localparam logic [7:0] CH_LOZ   = 8'h7A;
  localparam logic [7:0] CH_UPX   = 8'h58;
  localparam logic [7:0] CH_LOX   = 8'h78;

  typedef enum logic [2:0] {
    PH_WS    = 3'd0,
    PH_SIGN  = 3'd1,
    PH_ZERO  = 3'd2,
    PH_XPFX  = 3'd3,
    PH_DIGIT = 3'd4,
    PH_DONE  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_BADBASE = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last;
  } step_t;

  typedef struct packed {
    logic [63:0]      value;
    logic [POS_W-1:0] end_pos;
    status_t          status;
  } result_t;

  // Digit value of a character; DIG_NONE for anything that is no digit in any base.
  function automatic logic [DIG_W-1:0] char_value(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      t = c - CH_ZERO;
    end else if (c >= CH_UPA && c <= CH_UPZ) begin
      t = c - CH_UPA + 8'd10;
    end else if (c >= CH_LOA && c <= CH_LOZ) begin
      t = c - CH_LOA + 8'd10;
    end else begin
      t = 8'(DIG_NONE);
    end
    return t[DIG_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/t2i_mac.sv
// Multiply-accumulate of one digit with the saturation check against the signed limit.
module t2i_mac (
  input  logic [63:0]                 acc,
  input  logic [t2i_pkg::BASE_W-1:0]  base,
  input  logic [t2i_pkg::DIG_W-1:0]   digit,
  input  logic                        negative,
  output logic [63:0]                 acc_out,
  output logic                        ovf
);

  logic [69:0] prod;
  logic [70:0] sum;
  logic [63:0] limit;

  // acc * base + digit exceeds the limit exactly when acc > (limit - digit) / base.
  assign prod    = 70'(acc) * 70'(base);
  assign sum     = 71'(prod) + 71'(digit);
  assign limit   = negative ? t2i_pkg::NEG_MAX : t2i_pkg::POS_MAX;
  assign ovf     = sum > 71'(limit);
  assign acc_out = ovf ? limit : sum[63:0];

endmodule

FILE: hw/rtl/t2i_core.sv
// Per-string parse state; consumes one character per enabled cycle.
module t2i_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [t2i_pkg::BASE_W-1:0]  radix,
  input  logic                        go,
  input  t2i_pkg::step_t              step,
  output t2i_pkg::result_t            res
);

`include "text_to_int64_parser_macros.svh"

  t2i_pkg::phase_t                phase_r, phase_nxt, phase_eff;
  logic [63:0]                    acc_r, acc_nxt;
  logic                           neg_r, neg_nxt;
  logic [t2i_pkg::BASE_W-1:0]     base_r, base_nxt, base_cur, take_base;
  logic [t2i_pkg::POS_W-1:0]      pos_r, pos_nxt, end_r, end_nxt;
  logic                           ovf_r, ovf_nxt;
  logic                           bad, is_ws, is_zero, is_x, after_sign, take;
  logic [t2i_pkg::DIG_W-1:0]      digit;
  logic [63:0]                    mac_acc;
  logic                           mac_ovf;

  t2i_mac u_mac (
    .acc      (acc_r),
    .base     (take_base),
    .digit    (digit),
    .negative (neg_r),
    .acc_out  (mac_acc),
    .ovf      (mac_ovf)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= t2i_pkg::PH_WS;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      base_r  <= '0;
      pos_r   <= '0;
      end_r   <= '0;
      ovf_r   <= 1'b0;
    end else if (go) begin
      if (step.last) begin
        phase_r <= t2i_pkg::PH_WS;
        acc_r   <= '0;
        neg_r   <= 1'b0;
        base_r  <= '0;
        pos_r   <= '0;
        end_r   <= '0;
        ovf_r   <= 1'b0;
      end else begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        neg_r   <= neg_nxt;
        base_r  <= base_nxt;
        pos_r   <= pos_nxt;
        end_r   <= end_nxt;
        ovf_r   <= ovf_nxt;
      end
    end
  end

  // Character decode and the base that a digit is taken in.
  always_comb begin
    // The base is latched from the register on the first byte of a string.
    base_cur  = (phase_r == t2i_pkg::PH_WS && pos_r == '0) ? radix : base_r;
    bad       = (base_cur == t2i_pkg::BASE_ONE) || (base_cur > t2i_pkg::BASE_TOP);
    phase_eff = bad ? t2i_pkg::PH_DONE : phase_r;

    is_ws   = (step.char_byte == t2i_pkg::CH_SPACE) ||
              (step.char_byte >= t2i_pkg::CH_TAB && step.char_byte <= t2i_pkg::CH_CR);
    is_zero = (step.char_byte == t2i_pkg::CH_ZERO);
    is_x    = (step.char_byte == t2i_pkg::CH_UPX) || (step.char_byte == t2i_pkg::CH_LOX);
    digit   = t2i_pkg::char_value(step.char_byte);

    pos_nxt = (pos_r >= t2i_pkg::MAX_LEN) ? t2i_pkg::MAX_LEN : pos_r + 1'b1;

    // An undecided auto base becomes octal after a leading zero, hex after the
    // prefix and decimal otherwise. Only a byte taken as a digit uses it.
    take_base = base_cur;
    if (base_cur == t2i_pkg::BASE_AUTO) begin
      if (phase_eff == t2i_pkg::PH_ZERO) begin
        take_base = t2i_pkg::BASE_OCT;
      end else if (phase_eff == t2i_pkg::PH_XPFX) begin
        take_base = t2i_pkg::BASE_HEX;
      end else begin
        take_base = t2i_pkg::BASE_DEC;
      end
    end
  end

  always_comb begin
    phase_nxt  = phase_eff;
    acc_nxt    = acc_r;
    neg_nxt    = neg_r;
    base_nxt   = base_cur;
    end_nxt    = end_r;
    ovf_nxt    = ovf_r;
    after_sign = 1'b0;
    take       = 1'b0;

    unique case (phase_eff)
      t2i_pkg::PH_WS: begin
        if (is_ws) begin
          phase_nxt = t2i_pkg::PH_WS;
        end else if (step.char_byte == t2i_pkg::CH_MINUS ||
                     step.char_byte == t2i_pkg::CH_PLUS) begin
          neg_nxt   = (step.char_byte == t2i_pkg::CH_MINUS);
          phase_nxt = t2i_pkg::PH_SIGN;
        end else begin
          after_sign = 1'b1;
        end
      end
      t2i_pkg::PH_SIGN: begin
        after_sign = 1'b1;
      end
      t2i_pkg::PH_ZERO: begin
        if (is_x) begin
          phase_nxt = t2i_pkg::PH_XPFX;
        end else begin
          take = 1'b1;
        end
      end
      t2i_pkg::PH_XPFX: begin
        take = 1'b1;
      end
      t2i_pkg::PH_DIGIT: begin
        take = 1'b1;
      end
      default: begin
        phase_nxt = t2i_pkg::PH_DONE;
      end
    endcase

    if (after_sign) begin
      if ((base_cur == t2i_pkg::BASE_AUTO || base_cur == t2i_pkg::BASE_HEX) && is_zero) begin
        // A leading zero counts as converted and may open a hex prefix.
        acc_nxt   = '0;
        end_nxt   = pos_nxt;
        phase_nxt = t2i_pkg::PH_ZERO;
      end else begin
        take = 1'b1;
      end
    end

    if (take) begin
      base_nxt = take_base;
      if (digit < take_base) begin
        if (!ovf_r) begin
          acc_nxt = mac_acc;
          ovf_nxt = mac_ovf;
        end
        end_nxt   = pos_nxt;
        phase_nxt = t2i_pkg::PH_DIGIT;
      end else begin
        phase_nxt = t2i_pkg::PH_DONE;
      end
    end

    if (bad) begin
      res.value   = '0;
      res.end_pos = '0;
      res.status  = t2i_pkg::ST_BADBASE;
    end else begin
      res.value   = neg_nxt ? (64'd0 - acc_nxt) : acc_nxt;
      res.end_pos = end_nxt;
      res.status  = ovf_nxt ? t2i_pkg::ST_RANGE : t2i_pkg::ST_OK;
    end
  end

  `T2I_ASSERT_NEXT(a_clear_after_last, go && step.last,
    phase_r == t2i_pkg::PH_WS && pos_r == '0 && !ovf_r, "string state not cleared after last byte")
  `T2I_ASSERT_NOW(a_ovf_saturated, ovf_r,
    acc_r == t2i_pkg::POS_MAX || acc_r == t2i_pkg::NEG_MAX, "overflowed accumulator not at limit")
  `T2I_ASSERT_NOW(a_end_not_past_pos, go, end_r <= pos_r, "end position ahead of byte count")

endmodule

FILE: hw/rtl/text_to_int64_parser.sv
// out_valid rises when the last byte's result is loaded into the output register.
// One byte and one 64x6 multiply-add per cycle; a last byte waits on a full, stalled output.
// Reset (rst_n, synchronous, active low) empties both registers, clears the string state
// and sets the radix register to 10.
module text_to_int64_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [t2i_pkg::BASE_W-1:0]  cfg_radix,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_char_byte,
  input  logic                        in_last,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [63:0]          out_value,
  output logic [t2i_pkg::POS_W-1:0]   out_end_pos,
  output logic [1:0]                  out_status
);

`include "text_to_int64_parser_macros.svh"

  // The radix register is sampled by the core on the first byte of each string, so a
  // write only takes effect from the next string on.
  logic [t2i_pkg::BASE_W-1:0] radix_r;

  // Input register: holds one accepted item until the core consumes it.
  logic           in_vld_r;
  t2i_pkg::step_t step_r;

  // Output register: holds the result item until the downstream side takes it.
  logic             out_vld_r;
  t2i_pkg::result_t res_r;
  t2i_pkg::result_t res_core;

  logic go;

  // The core advances whenever it has an item, unless that item ends a string and the
  // output register is still full and stalled. Non-final bytes never wait for the output.
  assign go       = in_vld_r && (!step_r.last || !out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= t2i_pkg::BASE_DEC;
    end else if (cfg_we) begin
      radix_r <= cfg_radix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      step_r.char_byte <= in_char_byte;
      step_r.last      <= in_last;
    end
  end

  t2i_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .radix (radix_r),
    .go    (go),
    .step  (step_r),
    .res   (res_core)
  );

  // A new result overwrites the register only when it is empty or being taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (go && step_r.last) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && step_r.last) begin
      res_r <= res_core;
    end
  end

  assign out_valid   = out_vld_r;
  assign out_value   = res_r.value;
  assign out_end_pos = res_r.end_pos;
  assign out_status  = res_r.status;

  `T2I_ASSERT_NEXT(a_result_loaded, go && step_r.last, out_vld_r, "final byte gave no result")
  `T2I_ASSERT_NOW(a_badbase_zero, out_vld_r && res_r.status == t2i_pkg::ST_BADBASE,
    res_r.value == '0 && res_r.end_pos == '0, "invalid base result not zero")
  `T2I_ASSERT_NOW(a_range_limit, out_vld_r && res_r.status == t2i_pkg::ST_RANGE,
    res_r.value == t2i_pkg::POS_MAX || res_r.value == t2i_pkg::NEG_MAX,
    "out of range result not saturated")

endmodule
